// ----- rtl/core/ski_pkg.sv -----
// Shared types and codes for the sorted key index engine.
package ski_pkg;

	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_FIND   = 3'd1;
	localparam logic [2:0] OP_LOCATE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_SCAN   = 3'd4;

	localparam logic [2:0] RC_OK       = 3'd0;
	localparam logic [2:0] RC_DUP      = 3'd1;
	localparam logic [2:0] RC_FULL     = 3'd2;
	localparam logic [2:0] RC_NOTFOUND = 3'd3;
	localparam logic [2:0] RC_RANGE    = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] key_value;
		logic [31:0] new_offset;
		logic [7:0]  status_value;
		logic [9:0]  position;
		logic [5:0]  max_matches;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [10:0] position_out;
		logic [31:0] key_out;
		logic [31:0] offset_out;
		logic [7:0]  status_out;
		logic [10:0] count_out;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] offset;
		logic [7:0]  status;
	} entry_t;

endpackage

// ----- rtl/core/sorted_key_index_engine.sv -----
// Top level of the sorted key index engine.
// Keeps up to TABLE_DEPTH entries sorted by 32-bit key in one single-port-read memory and
// handles one request at a time. Lookups (insert, find, locate) take a binary search of
// about log2(count)+1 probes, then a decide step; read at position goes straight to the
// decide step; insert then shifts every later entry up one slot, one read and one write
// per entry, and writes the new entry into the freed slot; a status scan reads entries in
// order until the match limit or the end of the table. A result waiting in the output
// register holds off the next request. All timing is set by the one memory read port and
// its registered read data. No clearing pass is needed.
module sorted_key_index_engine import ski_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SRCH  = 3'd1;
	localparam logic [2:0] ST_SRCHW = 3'd2;
	localparam logic [2:0] ST_DECID = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;
	localparam logic [2:0] ST_SHFTW = 3'd5;
	localparam logic [2:0] ST_SCAN  = 3'd6;
	localparam logic [2:0] ST_SCANW = 3'd7;

	logic [2:0]    state_q;
	req_t          req_q;
	logic [CW-1:0] count_q, lo_q, hi_q, idx_q;
	logic [5:0]    nmatch_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	ski_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [CW-1:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;

	function automatic rsp_t mk(logic [2:0] c, logic [10:0] p, entry_t e,
			logic [CW-1:0] n, logic l);
		rsp_t r;
		r.result_code = c;
		r.position_out = p;
		r.key_out = e.key;
		r.offset_out = e.offset;
		r.status_out = e.status;
		r.count_out = 11'(n);
		r.last = l;
		return r;
	endfunction

	entry_t zero_e, in_e;
	assign zero_e = '0;
	assign in_e = '{key: req_q.key_value, offset: req_q.new_offset, status: req_q.status_value};

	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = mid[AW-1:0];
		case (state_q)
			ST_IDLE:  raddr = AW'(in_data.position);
			ST_SRCH:  raddr = mid[AW-1:0];
			// hold the address so the entry stays on rdata while the output is busy
			ST_DECID: raddr = lo_q[AW-1:0];
			ST_SHIFT: raddr = AW'(idx_q - 1'b1);
			ST_SHFTW: begin
				if (idx_q == lo_q) begin
					we = 1'b1;
					wdata = in_e;
				end else begin
					we = 1'b1;
				end
			end
			ST_SCAN:  raddr = idx_q[AW-1:0];
			ST_SCANW: raddr = idx_q[AW-1:0];
			default:  raddr = mid[AW-1:0];
		endcase
		if (state_q == ST_SHIFT && idx_q == lo_q) we = 1'b0;
		if (state_q == ST_SHFTW && idx_q == lo_q) begin
			we = 1'b1;
			wdata = in_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic ov_next;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			count_q <= '0;
		end else begin
			ov_next = out_valid && out_stall;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && out_free) begin
						req_q <= in_data;
						hi_q <= count_q;
						idx_q <= '0;
						nmatch_q <= '0;
						case (in_data.op)
							OP_INSERT, OP_FIND, OP_LOCATE: begin
								lo_q <= '0;
								state_q <= ST_SRCH;
							end
							OP_READ: begin
								if (32'(in_data.position) < 32'(count_q)) begin
									lo_q <= CW'(in_data.position);
									state_q <= ST_DECID;
								end else begin
									out_data <= mk(RC_RANGE, 11'(in_data.position), zero_e,
										count_q, 1'b1);
									ov_next = 1'b1;
								end
							end
							OP_SCAN: state_q <= ST_SCAN;
							default: begin
								out_data <= mk(RC_RANGE, '0, zero_e, count_q, 1'b1);
								ov_next = 1'b1;
							end
						endcase
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) state_q <= ST_SRCHW;
					else begin
						idx_q <= lo_q;
						state_q <= ST_DECID;
					end
				end
				ST_SRCHW: begin
					if (rdata.key < req_q.key_value) lo_q <= mid + 1'b1;
					else hi_q <= mid;
					state_q <= ST_SRCH;
				end
				ST_DECID: begin
					// rdata holds entry lo
					if (out_free) begin
						case (req_q.op)
							OP_READ: begin
								out_data <= mk(RC_OK, 11'(lo_q), rdata, count_q, 1'b1);
								ov_next = 1'b1;
								state_q <= ST_IDLE;
							end
							OP_FIND, OP_LOCATE: begin
								if (lo_q < count_q &&
										(req_q.op == OP_LOCATE || rdata.key == req_q.key_value))
									out_data <= mk(RC_OK, 11'(lo_q), rdata, count_q, 1'b1);
								else
									out_data <= mk(RC_NOTFOUND,
										(req_q.op == OP_LOCATE) ? 11'(count_q) : 11'd0,
										zero_e, count_q, 1'b1);
								ov_next = 1'b1;
								state_q <= ST_IDLE;
							end
							default: begin
								if (lo_q < count_q && rdata.key == req_q.key_value) begin
									out_data <= mk(RC_DUP, 11'(lo_q), rdata, count_q, 1'b1);
									ov_next = 1'b1;
									state_q <= ST_IDLE;
								end else if (count_q == CW'(TABLE_DEPTH)) begin
									out_data <= mk(RC_FULL, 11'(lo_q), in_e, count_q, 1'b1);
									ov_next = 1'b1;
									state_q <= ST_IDLE;
								end else begin
									idx_q <= count_q;
									state_q <= ST_SHIFT;
								end
							end
						endcase
					end
				end
				ST_SHIFT: state_q <= ST_SHFTW;
				ST_SHFTW: begin
					// rdata holds entry idx-1, written at idx
					if (idx_q == lo_q) begin
						count_q <= count_q + 1'b1;
						out_data <= mk(RC_OK, 11'(lo_q), in_e, count_q + 1'b1, 1'b1);
						ov_next = 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q - 1'b1;
						state_q <= ST_SHIFT;
					end
				end
				ST_SCAN: begin
					if (idx_q < count_q && nmatch_q < req_q.max_matches)
						state_q <= ST_SCANW;
					else if (out_free) begin
						out_data <= mk(RC_OK, '0, zero_e, CW'(nmatch_q), 1'b1);
						ov_next = 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SCANW: begin
					if (rdata.status == req_q.status_value) begin
						if (out_free) begin
							out_data <= mk(RC_OK, 11'(idx_q), rdata, CW'(nmatch_q + 1'b1), 1'b0);
							ov_next = 1'b1;
							nmatch_q <= nmatch_q + 1'b1;
							idx_q <= idx_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			out_valid <= ov_next;
		end
	end

endmodule

// ----- rtl/core/ski_store.sv -----
// Entry memory: one write port, one read port, registered read data.
module ski_store import ski_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
